/* hdl/stereo_mix_accumulate_clip_core_defines.svh */
// ----------------------------------------------------------------------------
// Stereo mix accumulate/clip core: assertion macros
// Shared assertion forms for the checker. Clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef STEREO_MIX_ACCUMULATE_CLIP_CORE_DEFINES_SVH
`define STEREO_MIX_ACCUMULATE_CLIP_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define SMAC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SMAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define SMAC_ASSERT_NEXT_NR(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/smac_pkg.sv */
// ----------------------------------------------------------------------------
// smac_pkg
// Shared types and constants for the stereo mix accumulate/clip core.
// ----------------------------------------------------------------------------
package smac_pkg;

    localparam int SLOTS   = 2048;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        CMD_ACC  = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_EMIT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_MASTER = 2'd0,
        REG_OUT8   = 2'd1,
        REG_STEREO = 2'd2,
        REG_RING   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [8:0] master_volume;
        logic       out_8bit;
        logic       out_stereo;
        logic [4:0] ring_log2;
    } t_cfg;

    // queue entry: a classified command, ready for the back end
    typedef struct packed {
        t_cmd                cmd;
        logic                slot_ok;
        logic [SLOT_AW-1:0]  slot;
        logic                is8;
        logic signed [24:0]  mprod;   // sample * master
        logic [8:0]          lfac;    // left volume factor
        logic [8:0]          rfac;    // right volume factor
        logic [31:0]         raw_left;
        logic [31:0]         raw_right;
        logic [15:0]         addr;    // ring address of first beat
    } t_qent;

endpackage

/* hdl/smac_if.sv */
// ----------------------------------------------------------------------------
// smac_if
// Valid/ready channels for command input and sample output.
// ----------------------------------------------------------------------------
interface smac_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [10:0]        slot;
    logic signed [15:0] sample_value;
    logic               sample_8bit;
    logic [8:0]         left_vol;
    logic [8:0]         right_vol;
    logic signed [31:0] raw_left;
    logic signed [31:0] raw_right;
    logic [31:0]        time_req;

    modport source (output valid, cmd, slot, sample_value, sample_8bit, left_vol,
                    right_vol, raw_left, raw_right, time_req, input ready);
    modport sink   (input valid, cmd, slot, sample_value, sample_8bit, left_vol,
                    right_vol, raw_left, raw_right, time_req, output ready);
endinterface

interface smac_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        out_addr;
    logic signed [15:0] out_value;
    logic               last;

    modport source (output valid, out_addr, out_value, last, input ready);
    modport sink   (input valid, out_addr, out_value, last, output ready);
endinterface

/* hdl/stereo_mix_accumulate_clip_core.sv */
// ----------------------------------------------------------------------------
// stereo_mix_accumulate_clip_core
// Stereo mix buffer: accumulate scaled samples, load slots, emit clipped
// 16-bit or offset 8-bit samples with output ring addresses.
// ----------------------------------------------------------------------------
//
//  port      dir   kind        carries
//  i_in      in    valid/rdy   one command beat (accumulate / load / emit)
//  o_out     out   valid/rdy   one output sample beat with ring address
//  psel..    in    APB         config writes/reads, 4 regs at 0x0..0xC
//
// Flow: the front end takes one beat per cycle, while the queue has room,
// into a 4-deep queue. The back end does each accumulate or load as a
// registered read of the single-port mix buffer, then the write-back, and
// each emit as one (mono) or two (stereo) beats; emits wait for the output
// register. Reset is synchronous, active low, and clears control only; the
// mix buffer has no clear, so a slot must be loaded before it is read.
// Commands with code 3, and loads/accumulates to slots >= SLOTS, are dropped
// at the front end and never reach the queue.
// ----------------------------------------------------------------------------
module stereo_mix_accumulate_clip_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smac_in_if.sink     i_in,
    smac_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    smac_pkg::t_cfg     r_cfg;
    smac_pkg::t_qent    f_ent;
    logic               f_valid;
    logic               q_ready;
    smac_pkg::t_qent    q_ent;
    logic               q_valid;
    logic               q_pop;
    smac_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = smac_pkg::t_reg_idx'(paddr[3:2]);

    // config regs, word addressed; byte offset bits ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.master_volume <= 9'd256;
            r_cfg.out_8bit      <= 1'b0;
            r_cfg.out_stereo    <= 1'b1;
            r_cfg.ring_log2     <= 5'd14;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                smac_pkg::REG_MASTER: r_cfg.master_volume <= pwdata[8:0];
                smac_pkg::REG_OUT8:   r_cfg.out_8bit      <= pwdata[0];
                smac_pkg::REG_STEREO: r_cfg.out_stereo    <= pwdata[0];
                smac_pkg::REG_RING:   r_cfg.ring_log2     <= pwdata[4:0];
                default:              r_cfg.ring_log2     <= r_cfg.ring_log2;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            smac_pkg::REG_MASTER: prdata = {23'd0, r_cfg.master_volume};
            smac_pkg::REG_OUT8:   prdata = {31'd0, r_cfg.out_8bit};
            smac_pkg::REG_STEREO: prdata = {31'd0, r_cfg.out_stereo};
            smac_pkg::REG_RING:   prdata = {27'd0, r_cfg.ring_log2};
            default:              prdata = 32'd0;
        endcase
    end

    // front: classify, pre-multiply by master volume, ring address
    smac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_ent       (f_ent),
        .o_ent_valid (f_valid),
        .i_ent_ready (q_ready)
    );

    // decoupling queue
    smac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_ent),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_ent),
        .i_pop   (q_pop)
    );

    // back: buffer read-modify-write and emit
    smac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ent_valid (q_valid),
        .i_ent       (q_ent),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

/* hdl/smac_front.sv */
// ----------------------------------------------------------------------------
// smac_front
// Accepts commands, drops no-ops, forms sample*master and ring address.
// ----------------------------------------------------------------------------
module smac_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    smac_in_if.sink            i_in,
    input  smac_pkg::t_cfg     i_cfg,
    output smac_pkg::t_qent    o_ent,
    output logic               o_ent_valid,
    input  logic               i_ent_ready
);

    logic               r_valid;
    smac_pkg::t_qent    r_ent;
    smac_pkg::t_qent    n_ent;
    logic               n_keep;
    logic               slot_ok;
    logic signed [16:0] s_ext;
    logic signed [26:0] prod;
    logic [4:0]         lv5;
    logic [4:0]         rv5;
    logic [4:0]         lg;
    logic [15:0]        mask;
    logic [15:0]        base;
    smac_pkg::t_cmd     cmd;

    assign i_in.ready  = !r_valid || i_ent_ready;
    assign o_ent_valid = r_valid;
    assign o_ent       = r_ent;

    always_comb begin
        cmd     = smac_pkg::t_cmd'(i_in.cmd);
        slot_ok = 32'(i_in.slot) < smac_pkg::SLOTS;
        // 8-bit path takes the low byte as signed
        s_ext = i_in.sample_8bit ? {{9{i_in.sample_value[7]}}, i_in.sample_value[7:0]}
                                 : {i_in.sample_value[15], i_in.sample_value};
        prod  = s_ext * $signed({1'b0, i_cfg.master_volume});
        lv5   = (i_in.left_vol  > 9'd255) ? 5'd31 : i_in.left_vol[7:3];
        rv5   = (i_in.right_vol > 9'd255) ? 5'd31 : i_in.right_vol[7:3];
        // ring size clamps to 2..65536
        if (i_cfg.ring_log2 == 5'd0) begin
            lg = 5'd1;
        end else if (i_cfg.ring_log2 > 5'd16) begin
            lg = 5'd16;
        end else begin
            lg = i_cfg.ring_log2;
        end
        mask = 16'((17'd1 << lg) - 17'd1);
        base = i_cfg.out_stereo ? {i_in.time_req[14:0], 1'b0} : i_in.time_req[15:0];

        n_ent.cmd       = cmd;
        n_ent.slot_ok   = slot_ok;
        n_ent.slot      = smac_pkg::SLOT_AW'(i_in.slot);
        n_ent.is8       = i_in.sample_8bit;
        n_ent.mprod     = 25'(prod);
        n_ent.lfac      = i_in.sample_8bit ? {4'd0, lv5} : i_in.left_vol;
        n_ent.rfac      = i_in.sample_8bit ? {4'd0, rv5} : i_in.right_vol;
        n_ent.raw_left  = i_in.raw_left;
        n_ent.raw_right = i_in.raw_right;
        n_ent.addr      = base & mask;

        case (cmd)
            smac_pkg::CMD_EMIT: n_keep = 1'b1;
            smac_pkg::CMD_ACC,
            smac_pkg::CMD_LOAD: n_keep = slot_ok;
            default:            n_keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= n_keep;
        end else if (i_ent_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ent <= n_ent;
        end
    end

endmodule

/* hdl/smac_fifo.sv */
// ----------------------------------------------------------------------------
// smac_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module smac_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  smac_pkg::t_qent    i_data,
    output logic               o_ready,
    output logic               o_valid,
    output smac_pkg::t_qent    o_data,
    input  logic               i_pop
);

    smac_pkg::t_qent                r_mem [smac_pkg::QDEPTH];
    logic [smac_pkg::QPTR_W-1:0]    r_wptr;
    logic [smac_pkg::QPTR_W-1:0]    r_rptr;
    logic [smac_pkg::QPTR_W:0]      r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_ready = r_count != (smac_pkg::QPTR_W+1)'(smac_pkg::QDEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* hdl/smac_back.sv */
// ----------------------------------------------------------------------------
// smac_back
// Mix buffer memories, volume scaling, accumulate/load/emit sequencer.
// ----------------------------------------------------------------------------
module smac_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smac_pkg::t_cfg     i_cfg,
    input  logic               i_ent_valid,
    input  smac_pkg::t_qent    i_ent,
    output logic               o_pop,
    smac_out_if.source         o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT_R
    } t_state;

    t_state                 r_state;
    smac_pkg::t_qent        r_cur;
    logic signed [34:0]     r_pl;
    logic signed [34:0]     r_pr;
    logic [31:0]            r_rd_l;
    logic [31:0]            r_rd_r;
    logic                   r_ov;
    logic [15:0]            r_oaddr;
    logic [15:0]            r_oval;
    logic                   r_olast;

    logic [31:0]            r_mem_l [smac_pkg::SLOTS];
    logic [31:0]            r_mem_r [smac_pkg::SLOTS];

    logic signed [40:0]     pl_x;
    logic signed [40:0]     pr_x;
    logic [31:0]            add_l;
    logic [31:0]            add_r;
    logic                   wr_en;
    logic [31:0]            n_wl;
    logic [31:0]            n_wr;
    logic                   out_free;
    logic [31:0]            emit_l;
    logic [31:0]            emit_r;
    logic                   emit_fire;
    logic                   n_ov;

    function automatic logic [15:0] emit_value(input logic [31:0] acc, input logic out8);
        logic [15:0] c16;
        begin
            // acc >>> 8 fits 16 bits when bits 31..23 agree
            if (acc[31:23] == {9{acc[31]}}) begin
                c16 = acc[23:8];
            end else begin
                c16 = acc[31] ? 16'h8000 : 16'h7fff;
            end
            emit_value = out8 ? {8'h00, c16[15:8] ^ 8'h80} : c16;
        end
    endfunction

    assign o_pop         = (r_state == S_IDLE) && i_ent_valid;
    assign out_free      = !r_ov || o_out.ready;
    assign o_out.valid   = r_ov;
    assign o_out.out_addr  = r_oaddr;
    assign o_out.out_value = r_oval;
    assign o_out.last      = r_olast;

    // output register loads a new beat, or keeps the one still waiting
    assign emit_fire = out_free &&
                       (((r_state == S_EXEC) && (r_cur.cmd == smac_pkg::CMD_EMIT)) ||
                        (r_state == S_EMIT_R));
    assign n_ov      = emit_fire || (r_ov && !o_out.ready);

    always_comb begin
        pl_x   = 41'(r_pl);
        pr_x   = 41'(r_pr);
        // 16-bit path: >>> 8; 8-bit path: * 8
        add_l  = r_cur.is8 ? {r_pl[28:0], 3'b000} : pl_x[39:8];
        add_r  = r_cur.is8 ? {r_pr[28:0], 3'b000} : pr_x[39:8];
        emit_l = r_cur.slot_ok ? r_rd_l : 32'd0;
        emit_r = r_cur.slot_ok ? r_rd_r : 32'd0;
        wr_en  = 1'b0;
        n_wl   = r_cur.raw_left;
        n_wr   = r_cur.raw_right;
        if (r_state == S_EXEC) begin
            case (r_cur.cmd)
                smac_pkg::CMD_ACC: begin
                    wr_en = 1'b1;
                    n_wl  = r_rd_l + add_l;
                    n_wr  = r_rd_r + add_r;
                end
                smac_pkg::CMD_LOAD: begin
                    wr_en = 1'b1;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_l <= r_mem_l[i_ent.slot];
            r_rd_r <= r_mem_r[i_ent.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_l[r_cur.slot] <= n_wl;
            r_mem_r[r_cur.slot] <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= n_ov;
            case (r_state)
                S_IDLE: begin
                    if (i_ent_valid) begin
                        r_cur   <= i_ent;
                        r_pl    <= i_ent.mprod * $signed({1'b0, i_ent.lfac});
                        r_pr    <= i_ent.mprod * $signed({1'b0, i_ent.rfac});
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cur.cmd == smac_pkg::CMD_EMIT) begin
                        if (out_free) begin
                            r_oaddr <= r_cur.addr;
                            r_oval  <= emit_value(emit_l, i_cfg.out_8bit);
                            r_olast <= !i_cfg.out_stereo;
                            r_state <= i_cfg.out_stereo ? S_EMIT_R : S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT_R: begin
                    if (out_free) begin
                        r_oaddr <= r_cur.addr | 16'd1;
                        r_oval  <= emit_value(emit_r, i_cfg.out_8bit);
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/smac_checker.sv */
// ----------------------------------------------------------------------------
// smac_checker
// Port-level checks on the output channel and config port.
// ----------------------------------------------------------------------------
`include "stereo_mix_accumulate_clip_core_defines.svh"

module smac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_addr,
    input logic [15:0] i_out_value,
    input logic        i_out_last,
    input logic        i_pready
);

    // held beat keeps its payload
    `SMAC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_addr) && $stable(i_out_value) && $stable(i_out_last), "output beat changed while stalled")

    // no output right after reset
    `SMAC_ASSERT_NEXT_NR(a_out_rst, !i_rst_n, !i_out_valid, "output valid after reset")

    // a non-final beat is a stereo left sample: even ring address
    `SMAC_ASSERT_IMPL(a_left_even, i_out_valid && !i_out_last, !i_out_addr[0], "left beat on odd address")

    `SMAC_ASSERT_IMPL(a_pready, 1'b1, i_pready, "pready dropped")

endmodule

bind stereo_mix_accumulate_clip_core smac_checker u_smac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_addr  (o_out.out_addr),
    .i_out_value (o_out.out_value),
    .i_out_last  (o_out.last),
    .i_pready    (pready)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stereo mix accumulate/clip core testbench
// Drives load, accumulate and emit beats with random bursts against a random
// output stall pattern. Every accepted command goes through a bit-exact mix
// buffer predictor in a small scoreboard class, and each output beat is
// checked field by field against the oldest predicted sample. The run steps
// through several register settings, the extremes among them, written over
// APB while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import smac_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;  // unused code, core drops it
    localparam int PHASE_ITEMS  = 55;        // counted beats per random phase
    localparam int NUM_PHASES   = 8;
    localparam int SETTLE       = 24;        // queue + back end + output reg
    localparam int HOLD_CYCLES  = 300;       // long output stall
    localparam int STALL_LIMIT  = 5000;      // cycles without any handshake

    // one command beat as the testbench sees it
    typedef struct {
        logic [1:0]         cmd;
        logic [10:0]        slot;
        logic signed [15:0] sample_value;
        logic               sample_8bit;
        logic [8:0]         left_vol;
        logic [8:0]         right_vol;
        logic signed [31:0] raw_left;
        logic signed [31:0] raw_right;
        logic [31:0]        time_req;
    } cmd_beat_t;

    // one predicted output sample beat
    typedef struct {
        logic [15:0] addr;
        logic [15:0] value;
        logic        last;
    } sample_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of the mix buffer and the registers; emits
    // push predicted samples, the output monitor pops and compares them.
    // ------------------------------------------------------------------------
    class mix_buffer_sb;
        bit [31:0]    left_acc [SLOTS];
        bit [31:0]    right_acc[SLOTS];
        bit [8:0]     master_vol = 9'd256;
        bit           out_8bit   = 1'b0;
        bit           out_stereo = 1'b1;
        bit [4:0]     ring_log2  = 5'd14;
        sample_beat_t pending_samples[$];
        int unsigned  mismatches = 0;

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_MASTER: master_vol = val[8:0];
                REG_OUT8:   out_8bit   = val[0];
                REG_STEREO: out_stereo = val[0];
                REG_RING:   ring_log2  = val[4:0];
                default: ;
            endcase
        endfunction

        // volume-scaled increment for one side
        function bit [31:0] scaled_add(cmd_beat_t b, bit [8:0] vol);
            longint smp;
            longint fac;
            longint prod;
            if (b.sample_8bit) begin
                // signed low byte, volume clamped to 255, 5-bit volume step
                smp = longint'($signed(b.sample_value[7:0]));
                fac = (vol > 9'd255) ? 255 : longint'(vol);
                fac = (fac >> 3) * 8 * longint'(master_vol);
                return 32'(smp * fac);
            end else begin
                smp  = longint'(b.sample_value);
                prod = smp * longint'(vol) * longint'(master_vol);
                return 32'(prod >>> 8);
            end
        endfunction

        // accumulator -> clipped 16-bit or offset 8-bit sample
        function bit [15:0] out_sample(bit [31:0] acc);
            longint v;
            v = longint'($signed(acc)) >>> 8;
            if (v > 32767)
                v = 32767;
            else if (v < -32768)
                v = -32768;
            if (out_8bit)
                v = (v >>> 8) + 128;
            return v[15:0];
        endfunction

        function void take_command(cmd_beat_t b);
            bit [31:0]    base;
            bit [31:0]    mask;
            int           lg;
            sample_beat_t s;
            case (b.cmd)
                CMD_ACC: begin
                    left_acc[b.slot]  += scaled_add(b, b.left_vol);
                    right_acc[b.slot] += scaled_add(b, b.right_vol);
                end
                CMD_LOAD: begin
                    left_acc[b.slot]  = b.raw_left;
                    right_acc[b.slot] = b.raw_right;
                end
                CMD_EMIT: begin
                    // ring size clamps to 2..65536 samples
                    lg = (ring_log2 < 1) ? 1 : (ring_log2 > 16) ? 16 : int'(ring_log2);
                    mask = (32'd1 << lg) - 32'd1;
                    base = b.time_req * (out_stereo ? 32'd2 : 32'd1);
                    s.addr  = 16'(base & mask);
                    s.value = out_sample(left_acc[b.slot]);
                    s.last  = !out_stereo;
                    pending_samples.push_back(s);
                    if (out_stereo) begin
                        s.addr  = 16'((base + 32'd1) & mask);
                        s.value = out_sample(right_acc[b.slot]);
                        s.last  = 1'b1;
                        pending_samples.push_back(s);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic [15:0] addr, logic [15:0] value, logic last);
            sample_beat_t s;
            if (pending_samples.size() == 0) begin
                $error("unexpected output beat: out_addr %h out_value %h last %b",
                       addr, value, last);
                mismatches++;
                return;
            end
            s = pending_samples.pop_front();
            if (addr !== s.addr) begin
                $error("out_addr: expected %h, actual %h", s.addr, addr);
                mismatches++;
            end
            if (value !== s.value) begin
                $error("out_value: expected %h, actual %h", s.value, value);
                mismatches++;
            end
            if (last !== s.last) begin
                $error("last: expected %b, actual %b", s.last, last);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    smac_in_if  cmd_if ();
    smac_out_if smp_if ();

    stereo_mix_accumulate_clip_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (smp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    mix_buffer_sb sb;

    // stimulus bookkeeping: only loaded slots may be read back
    bit       slot_loaded[SLOTS];
    int       loaded_slots[$];
    int       burst_left = 0;
    bit       gaps_on    = 1'b1;
    bit       hold_req   = 1'b0;
    int       stall_cycles = 0;

    // ------------------------------------------------------------------------
    // Drivers: everything changes on the falling edge, handshakes are
    // sampled on the rising edge.
    // ------------------------------------------------------------------------
    task automatic idle_in(int n);
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // one command beat; bursts of random length, separated by random gaps while gaps_on is set
    task automatic send_beat(cmd_beat_t b);
        if (burst_left == 0) begin
            if (gaps_on)
                idle_in($urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        cmd_if.valid        = 1'b1;
        cmd_if.cmd          = b.cmd;
        cmd_if.slot         = b.slot;
        cmd_if.sample_value = b.sample_value;
        cmd_if.sample_8bit  = b.sample_8bit;
        cmd_if.left_vol     = b.left_vol;
        cmd_if.right_vol    = b.right_vol;
        cmd_if.raw_left     = b.raw_left;
        cmd_if.raw_right    = b.raw_right;
        cmd_if.time_req     = b.time_req;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.take_command(b);
        if (b.cmd == CMD_LOAD && !slot_loaded[b.slot]) begin
            slot_loaded[b.slot] = 1'b1;
            loaded_slots.push_back(int'(b.slot));
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // stop sending and wait for every predicted sample to come out
    task automatic drain_samples();
        idle_in(1);
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
    endtask

    // drain, then give the back end time to retire trailing loads/accs
    task automatic quiesce();
        drain_samples();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic cmd_beat_t mk_beat(logic [1:0] cmd, int slot,
                                          logic signed [15:0] smp, bit is8,
                                          int lv, int rv, logic [31:0] rl,
                                          logic [31:0] rr, logic [31:0] t);
        cmd_beat_t b;
        b.cmd = cmd; b.slot = 11'(slot); b.sample_value = smp; b.sample_8bit = is8;
        b.left_vol = 9'(lv); b.right_vol = 9'(rv); b.raw_left = rl; b.raw_right = rr;
        b.time_req = t;
        return b;
    endfunction

    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        int        pick;
        pick = $urandom_range(0, 99);
        b.slot         = 11'($urandom_range(0, SLOTS - 1));
        b.sample_8bit  = 1'($urandom_range(0, 1));
        b.left_vol     = 9'($urandom_range(0, 511));
        b.right_vol    = 9'($urandom_range(0, 511));
        b.raw_left     = $signed($urandom) >>> $urandom_range(0, 24);
        b.raw_right    = $signed($urandom) >>> $urandom_range(0, 24);
        b.time_req     = $urandom;
        b.sample_value = 16'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: b.sample_value = 16'sh7fff;
                1: b.sample_value = 16'sh8000;
                2: b.sample_value = 16'sh0000;
                default: b.sample_value = -16'sd1;
            endcase
        end
        if (pick < 5) begin
            b.cmd = CMD_NONE;
        end else if (pick < 25 || loaded_slots.size() == 0) begin
            // mostly a small working set so slots get hit repeatedly
            b.cmd = CMD_LOAD;
            if ($urandom_range(0, 3) != 0)
                b.slot = 11'($urandom_range(0, 31));
        end else begin
            b.cmd  = (pick < 75) ? CMD_ACC : CMD_EMIT;
            b.slot = 11'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
        end
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: stall pattern changes every stretch; a hold request
    // forces a long stall so the queue fills and input backs up.
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        int len;
        smp_if.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(20, 80);
            repeat (len) begin
                @(negedge i_clk);
                if (hold_req) begin
                    smp_if.ready = 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: smp_if.ready = 1'b1;
                        1: smp_if.ready = 1'($urandom_range(0, 1));
                        2: smp_if.ready = ($urandom_range(0, 3) == 0);
                        default: smp_if.ready = !smp_if.ready;
                    endcase
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && smp_if.valid && smp_if.ready)
            sb.check_sample(smp_if.out_addr, smp_if.out_value, smp_if.last);
    end

    // watchdog: counts cycles without any handshake
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (smp_if.valid && smp_if.ready) ||
            (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cmd_beat_t b;
        int        n;
        sb = new;
        cmd_if.valid = 1'b0;
        cmd_if.cmd = CMD_ACC; cmd_if.slot = '0; cmd_if.sample_value = '0;
        cmd_if.sample_8bit = 1'b0; cmd_if.left_vol = '0; cmd_if.right_vol = '0;
        cmd_if.raw_left = '0; cmd_if.raw_right = '0; cmd_if.time_req = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at reset settings
        // clip at both rails
        send_beat(mk_beat(CMD_LOAD, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0));
        send_beat(mk_beat(CMD_EMIT, 0, 0, 0, 0, 0, 0, 0, 0));
        // top slot: extreme 16-bit sample and volume, 8-bit clamp and byte
        // extraction with junk upper byte, volume below the 8-bit step
        send_beat(mk_beat(CMD_LOAD, 2047, 0, 0, 0, 0, 0, 0, 0));
        send_beat(mk_beat(CMD_ACC, 2047, -16'sd32768, 0, 511, 0, 0, 0, 0));
        send_beat(mk_beat(CMD_ACC, 2047, 16'sh5a80, 1, 511, 255, 0, 0, 0));
        send_beat(mk_beat(CMD_ACC, 2047, 16'sh807f, 1, 7, 8, 0, 0, 0));
        send_beat(mk_beat(CMD_EMIT, 2047, 0, 0, 0, 0, 0, 0, 32'hffffffff));
        // tiny negatives must floor, not truncate toward zero
        send_beat(mk_beat(CMD_LOAD, 1, 0, 0, 0, 0, 32'hffffffff, 32'h000000ff, 0));
        send_beat(mk_beat(CMD_ACC, 1, 16'sh7fff, 0, 511, 511, 0, 0, 0));
        send_beat(mk_beat(CMD_ACC, 1, -16'sd1, 0, 1, 0, 0, 0, 0));
        send_beat(mk_beat(CMD_EMIT, 1, 0, 0, 0, 0, 0, 0, 32'h00012345));
        // unused command code carries junk and must do nothing
        send_beat(mk_beat(CMD_NONE, 1, 16'sh1234, 1, 511, 511, 32'hdeadbeef,
                          32'hcafef00d, 32'h55aa55aa));
        send_beat(mk_beat(CMD_LOAD, 1024, 0, 0, 0, 0, 32'h00ffff00, 32'hffff0000, 0));
        send_beat(mk_beat(CMD_EMIT, 1024, 0, 0, 0, 0, 0, 0, 32'h7fffffff));
        // back-to-back read-after-write on one slot
        send_beat(mk_beat(CMD_LOAD, 2, 0, 0, 0, 0, 32'h00007fff, 32'hffff8000, 0));
        send_beat(mk_beat(CMD_EMIT, 2, 0, 0, 0, 0, 0, 0, 32'd3));
        send_beat(mk_beat(CMD_ACC, 2, 16'sh4000, 0, 256, 128, 0, 0, 0));
        send_beat(mk_beat(CMD_EMIT, 2, 0, 0, 0, 0, 0, 0, 32'd4));
        send_beat(mk_beat(CMD_ACC, 2, 16'sh00ff, 1, 300, 9, 0, 0, 0));
        send_beat(mk_beat(CMD_ACC, 2, -16'sd20000, 0, 100, 511, 0, 0, 0));
        send_beat(mk_beat(CMD_EMIT, 2, 0, 0, 0, 0, 0, 0, 32'd5));

        // random phases, each with its own register setting
        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            quiesce();
            case (ph)
                1: begin
                    write_reg(REG_MASTER, 32'd0);
                    write_reg(REG_OUT8, 32'd1);
                    write_reg(REG_STEREO, 32'd0);
                    write_reg(REG_RING, 32'd1);
                end
                2: begin
                    write_reg(REG_MASTER, 32'd511);
                    write_reg(REG_OUT8, 32'd0);
                    write_reg(REG_STEREO, 32'd1);
                    write_reg(REG_RING, 32'd16);
                end
                3: begin
                    write_reg(REG_MASTER, 32'd256);
                    write_reg(REG_OUT8, 32'd1);
                    write_reg(REG_STEREO, 32'd1);
                    write_reg(REG_RING, 32'd0);     // acts as 1
                end
                4: begin
                    write_reg(REG_MASTER, $urandom_range(0, 511));
                    write_reg(REG_OUT8, 32'd0);
                    write_reg(REG_STEREO, 32'd0);
                    write_reg(REG_RING, 32'd31);    // acts as 16
                end
                5: begin
                    write_reg(REG_MASTER, 32'd1);
                    write_reg(REG_OUT8, 32'd0);
                    write_reg(REG_STEREO, 32'd1);
                    write_reg(REG_RING, $urandom_range(1, 16));
                end
                default: begin
                    write_reg(REG_MASTER, $urandom_range(0, 511));
                    write_reg(REG_OUT8, $urandom_range(0, 1));
                    write_reg(REG_STEREO, $urandom_range(0, 1));
                    write_reg(REG_RING, $urandom_range(0, 31));
                end
            endcase
            gaps_on = (ph != 4);    // one phase at full input rate
            n = 0;
            while (n < PHASE_ITEMS) begin
                b = random_beat();
                send_beat(b);
                if (b.cmd != CMD_NONE) begin
                    n++;
                    // long output stall with input still offered
                    if ((ph == 2 || ph == 6) && n == 10)
                        hold_req = 1'b1;
                    // sender pauses mid-phase until the output catches up
                    if (ph == 3 && n == 25)
                        drain_samples();
                end
            end
        end

        quiesce();
        if (sb.mismatches == 0 && sb.pending_samples.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
